// ----- sv/bq_pkg.sv -----
package bq_pkg;

  localparam int COEF_WIDTH_DEF  = 18;
  localparam int STATE_WIDTH_DEF = 32;
  localparam int SAMPLE_W        = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int A0_RESET        = 65535;
  localparam int B0_RESET        = 65535;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A0 = 3'd0,
    REG_A1 = 3'd1,
    REG_A2 = 3'd2,
    REG_B0 = 3'd3,
    REG_B1 = 3'd4,
    REG_B2 = 3'd5
  } bq_reg_t;

  typedef struct packed {
    logic sub;
    logic gate_b;
  } bq_alu_ctl_t;

endpackage

// ----- sv/bq_alu.sv -----
module bq_alu import bq_pkg::*; #(
  parameter int W = 51
) (
  input  logic [W-1:0] opa,
  input  logic [W-1:0] opb,
  input  bq_alu_ctl_t  ctl,
  output logic [W-1:0] res
);

  logic [W-1:0] b_gated;
  logic [W-1:0] b_final;

  assign b_gated = ctl.gate_b ? opb : '0;
  assign b_final = ctl.sub ? ~b_gated : b_gated;
  assign res     = opa + b_final + W'(ctl.sub);

endmodule

// ----- sv/biquad_iir_filter.sv -----
// Direct form II biquad on signed 16-bit samples with six integer coefficients
// written through the cfg port. The user must write them only while the filter
// is idle; the block itself does not enforce this. All arithmetic runs on one
// shared add/subtract unit of STATE_WIDTH+COEF_WIDTH+1 bits: each of the six
// products is a shift-add over the COEF_WIDTH bits of its coefficient and each
// of the two divisions by coef_a0 is a restoring division of one quotient bit
// per cycle. From an accepted request until its result moves into the output
// register, in_tready stays low. A finished result sits in the output register
// and the filter takes the next request while it waits there.
module biquad_iir_filter import bq_pkg::*; #(
  parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,    // [15:0] sample_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SAMPLE_W-1:0]   out_tdata,   // [15:0] sample_out
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_WIDTH-1:0] cfg_data
);

  localparam int CW    = COEF_WIDTH;
  localparam int SW    = STATE_WIDTH;
  localparam int SUM_W = SW + CW + 1;
  localparam int CNT_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MAC, S_ABS, S_DIV, S_FIX, S_HOLD
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-2:0]       a0_r, a0_nxt;
  logic [CW-1:0]       a1_r, a1_nxt, a2_r, a2_nxt;
  logic [CW-1:0]       b0_r, b0_nxt, b1_r, b1_nxt, b2_r, b2_nxt;
  logic [SW-1:0]       d0_r, d0_nxt, d1_r, d1_nxt, fb_r, fb_nxt;
  logic [SAMPLE_W-1:0] x_r, x_nxt, y_r, y_nxt, out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                phase_r, phase_nxt;
  logic [1:0]          term_r, term_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [CW-1:0]       mplier_r, mplier_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic                negt_r, negt_nxt, neg_r, neg_nxt;

  logic [SUM_W-1:0]    alu_a, alu_b, alu_res;
  bq_alu_ctl_t         alu_ctl;
  logic [SUM_W-1:0]    term_a;
  logic [CW-1:0]       term_b;
  logic                term_neg;
  logic [CW-1:0]       rem_sh;
  logic                fits;
  logic                ovf_s, ovf_y, a0_zero;

  bq_alu #(.W(SUM_W)) u_alu (
    .opa (alu_a),
    .opb (alu_b),
    .ctl (alu_ctl),
    .res (alu_res)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  assign rem_sh  = {rem_r[CW-2:0], acc_r[SUM_W-2]};
  assign fits    = ~alu_res[SUM_W-1];
  assign ovf_s   = |acc_r[SUM_W-2:SW-1];
  assign ovf_y   = |acc_r[SUM_W-2:SAMPLE_W-1];
  assign a0_zero = (a0_r == '0);

  always_comb begin
    case (term_r)
      2'd0: begin
        term_a   = phase_r ? {{(SUM_W-SW){fb_r[SW-1]}}, fb_r}
                           : {{(SUM_W-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r};
        term_b   = phase_r ? b0_r : {1'b0, a0_r};
        term_neg = 1'b0;
      end
      2'd1: begin
        term_a   = {{(SUM_W-SW){d0_r[SW-1]}}, d0_r};
        term_b   = phase_r ? b1_r : a1_r;
        term_neg = ~phase_r;
      end
      default: begin
        term_a   = {{(SUM_W-SW){d1_r[SW-1]}}, d1_r};
        term_b   = phase_r ? b2_r : a2_r;
        term_neg = ~phase_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    a0_nxt        = a0_r;
    a1_nxt        = a1_r;
    a2_nxt        = a2_r;
    b0_nxt        = b0_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    d0_nxt        = d0_r;
    d1_nxt        = d1_r;
    fb_nxt        = fb_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    phase_nxt     = phase_r;
    term_nxt      = term_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    rem_nxt       = rem_r;
    negt_nxt      = negt_r;
    neg_nxt       = neg_r;
    alu_a         = acc_r;
    alu_b         = mcand_r;
    alu_ctl       = '{sub: 1'b0, gate_b: 1'b0};

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_A0:  a0_nxt = cfg_data[CW-2:0];
        REG_A1:  a1_nxt = cfg_data;
        REG_A2:  a2_nxt = cfg_data;
        REG_B0:  b0_nxt = cfg_data;
        REG_B1:  b1_nxt = cfg_data;
        REG_B2:  b2_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          x_nxt     = in_tdata;
          phase_nxt = 1'b0;
          term_nxt  = 2'd0;
          acc_nxt   = '0;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        mcand_nxt  = term_a;
        mplier_nxt = term_b;
        negt_nxt   = term_neg;
        cnt_nxt    = '0;
        state_nxt  = S_MAC;
      end
      S_MAC: begin
        alu_a      = acc_r;
        alu_b      = mcand_r;
        alu_ctl    = '{sub: negt_r ^ (cnt_r == CNT_W'(CW-1)), gate_b: mplier_r[0]};
        acc_nxt    = alu_res;
        mcand_nxt  = {mcand_r[SUM_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[CW-1:1]};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CW-1)) begin
          if (term_r == 2'd2) begin
            state_nxt = S_ABS;
          end else begin
            term_nxt  = term_r + 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      S_ABS: begin
        alu_a     = '0;
        alu_b     = acc_r;
        alu_ctl   = '{sub: acc_r[SUM_W-1], gate_b: 1'b1};
        acc_nxt   = alu_res;
        neg_nxt   = acc_r[SUM_W-1];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        alu_a   = {{(SUM_W-CW){1'b0}}, rem_sh};
        alu_b   = {{(SUM_W-CW+1){1'b0}}, a0_r};
        alu_ctl = '{sub: 1'b1, gate_b: 1'b1};
        rem_nxt = fits ? alu_res[CW-1:0] : rem_sh;
        acc_nxt = {1'b0, acc_r[SUM_W-3:0], fits};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SUM_W-2)) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        alu_a   = '0;
        alu_b   = acc_r;
        alu_ctl = '{sub: neg_r, gate_b: 1'b1};
        if (!phase_r) begin
          if (a0_zero) begin
            fb_nxt = '0;
          end else if (ovf_s) begin
            fb_nxt = neg_r ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
          end else begin
            fb_nxt = alu_res[SW-1:0];
          end
          phase_nxt = 1'b1;
          term_nxt  = 2'd0;
          acc_nxt   = '0;
          state_nxt = S_LOAD;
        end else begin
          if (a0_zero) begin
            y_nxt = '0;
          end else if (ovf_y) begin
            y_nxt = neg_r ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                          : {1'b0, {(SAMPLE_W-1){1'b1}}};
          end else begin
            y_nxt = alu_res[SAMPLE_W-1:0];
          end
          d1_nxt    = d0_r;
          d0_nxt    = fb_r;
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = y_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      a0_r        <= (CW-1)'(A0_RESET);
      a1_r        <= '0;
      a2_r        <= '0;
      b0_r        <= CW'(B0_RESET);
      b1_r        <= '0;
      b2_r        <= '0;
      d0_r        <= '0;
      d1_r        <= '0;
      phase_r     <= 1'b0;
      term_r      <= 2'd0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      a0_r        <= a0_nxt;
      a1_r        <= a1_nxt;
      a2_r        <= a2_nxt;
      b0_r        <= b0_nxt;
      b1_r        <= b1_nxt;
      b2_r        <= b2_nxt;
      d0_r        <= d0_nxt;
      d1_r        <= d1_nxt;
      phase_r     <= phase_nxt;
      term_r      <= term_nxt;
      cnt_r       <= cnt_nxt;
    end
    fb_r       <= fb_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    out_data_r <= out_data_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    rem_r      <= rem_nxt;
    negt_r     <= negt_nxt;
    neg_r      <= neg_nxt;
  end

  // The remainder stays below the divisor throughout the division.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !a0_zero) |-> (rem_r < {1'b0, a0_r}))
    else $error("division remainder not below divisor");

  // The magnitude being divided never has its sign bit set.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !acc_r[SUM_W-1])
    else $error("division operand sign bit set");

  // An accepted request keeps the input closed in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input reopened right after a request");

  // A new result is only loaded when the output register is free or drained.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && out_valid_r && !out_tready) |=> $stable(out_tdata))
    else $error("pending result overwritten");

endmodule
